// File: hdl/b64d_pkg.sv
// types, constants and character map shared by the url-safe base64 decoder
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_input;
   } b64d_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic       is_last;
   } b64d_rsp_type;

   typedef struct packed {
      logic [1:0]  count;
      logic [17:0] acc;
      logic        stopped;
   } b64d_state_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } b64d_sextet_type;

   // url-safe alphabet to 6-bit value
   function automatic b64d_sextet_type sextet_of(input logic [7:0] ch);
      b64d_sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (ch >= 8'h41 && ch <= 8'h5a) begin
         s.value = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7a) begin
         s.value = 6'(ch - 8'h61 + 8'd26);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         s.value = 6'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2d) begin
         s.value = 6'd62;
      end else if (ch == 8'h5f) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// File: hdl/base64url_stream_decoder_core.sv
// top level of the url-safe base64 stream decoder
// Usage:
//   req channel carries one character per word (symbol, end_of_input);
//   rsp channel carries decoded bytes (out_byte, has_data, is_last).
//   A word is taken when valid is high and stall is low on that channel.
// Path: a taken word is held in the input register, and its results are then
//   loaded into the result buffer, whose front word drives rsp.
// Throughput: one word per cycle while each word gives at most one result and
//   rsp_stall is low. A word that gives several results holds the result buffer
//   until they drain one byte a cycle while rsp_stall is low; req_stall rises meanwhile.
// A full group of four characters gives three bytes; a partial group is
//   flushed at end_of_input or at an invalid character. end_of_input marks the
//   last result with is_last, giving a bare marker when no byte is due.
// Reset clears the group state, the input-register valid flag and the result-buffer count.
// While rsp_stall is high the front result word holds still; one new word can
//   still be taken into the input register.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_decoder_core
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  b64d_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output b64d_rsp_type rsp_data
);

   logic           in_valid_ff, in_valid_in;
   b64d_req_type   in_word_ff;
   b64d_state_type state_ff, state_in, state_dec;
   b64d_rsp_type   res_ff [MAX_RESULTS];
   b64d_rsp_type   res_in [MAX_RESULTS];
   b64d_rsp_type   batch  [MAX_RESULTS];
   logic [1:0]     cnt_ff, cnt_in, batch_count;
   logic           advance, pop;

   b64d_decode u_decode (
      .state_cur   (state_ff),
      .req_word    (in_word_ff),
      .state_nxt   (state_dec),
      .batch       (batch),
      .batch_count (batch_count)
   );

   // buffer free when empty, or once the last pending byte leaves this cycle
   assign advance   = in_valid_ff && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && !rsp_stall));
   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = res_ff[0];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      state_in = advance ? state_dec : state_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      if (advance) begin
         res_in = batch;
         cnt_in = batch_count;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_in[i] = res_ff[i + 1];
         end
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         cnt_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

// File: hdl/b64d_decode.sv
// per-word decode: next group state and the batch of up to three result words
`timescale 1ns / 1ps
`default_nettype none

module b64d_decode
   import b64d_pkg::*;
(
   input  b64d_state_type state_cur,
   input  b64d_req_type   req_word,
   output b64d_state_type state_nxt,
   output b64d_rsp_type   batch [MAX_RESULTS],
   output logic [1:0]     batch_count
);

   b64d_sextet_type sx;
   logic [23:0]     group;
   logic [1:0]      cnt;
   logic [17:0]     acc;
   logic            stp;
   logic [1:0]      n;
   logic            do_flush;

   always_comb begin
      sx    = sextet_of(req_word.symbol);
      group = {state_cur.acc, sx.value};
      cnt   = state_cur.count;
      acc   = state_cur.acc;
      stp   = state_cur.stopped;
      n     = 2'd0;
      do_flush = 1'b0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         batch[i] = '0;
      end

      if (!stp) begin
         if (sx.valid) begin
            if (cnt == 2'd3) begin
               batch[0] = '{out_byte: group[23:16], has_data: 1'b1, is_last: 1'b0};
               batch[1] = '{out_byte: group[15:8],  has_data: 1'b1, is_last: 1'b0};
               batch[2] = '{out_byte: group[7:0],   has_data: 1'b1, is_last: 1'b0};
               n   = 2'd3;
               cnt = 2'd0;
               acc = '0;
            end else begin
               acc = group[17:0];
               cnt = cnt + 2'd1;
            end
         end else if ((req_word.symbol == CHAR_CR || req_word.symbol == CHAR_LF)
                      && cnt == 2'd0) begin
            // line break between groups is skipped
         end else begin
            do_flush = 1'b1;
            stp      = 1'b1;
         end
      end

      if (req_word.end_of_input && !stp) begin
         do_flush = 1'b1;
      end

      // at most one flush per word; it adds bytes only when n is still zero, as a full group leaves cnt at zero
      if (do_flush) begin
         if (cnt == 2'd2) begin
            batch[0] = '{out_byte: acc[11:4], has_data: 1'b1, is_last: 1'b0};
            n = 2'd1;
         end else if (cnt == 2'd3) begin
            batch[0] = '{out_byte: acc[17:10], has_data: 1'b1, is_last: 1'b0};
            batch[1] = '{out_byte: acc[9:2],   has_data: 1'b1, is_last: 1'b0};
            n = 2'd2;
         end
         cnt = 2'd0;
         acc = '0;
      end

      if (req_word.end_of_input) begin
         if (n == 2'd0) begin
            batch[0] = '{out_byte: 8'd0, has_data: 1'b0, is_last: 1'b0};
            n = 2'd1;
         end
         batch[n - 2'd1].is_last = 1'b1;
         cnt = 2'd0;
         acc = '0;
         stp = 1'b0;
      end

      state_nxt.count   = cnt;
      state_nxt.acc     = acc;
      state_nxt.stopped = stp;
      batch_count       = n;
   end

endmodule

`default_nettype wire

// File: hdl/b64d_checker.sv
// port-level checks for the url-safe base64 stream decoder
`timescale 1ns / 1ps
`default_nettype none

module b64d_checker
   import b64d_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire b64d_req_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire b64d_rsp_type rsp_data
);

   // nothing is shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // a word without data is only ever the bare end marker
   a_bare_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_data |-> rsp_data.is_last)
      else $error("bare word not marked last");

   a_bare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_data |-> rsp_data.out_byte == 8'd0)
      else $error("bare end marker carries a byte");

   // the input side only stalls while a word sits in the input register,
   // which needs a word taken earlier
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall && !$past(reset) |-> $past(req_valid) || $past(req_stall))
      else $error("input stalled with nothing taken");

endmodule

bind base64url_stream_decoder_core b64d_checker u_b64d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
